FILE: src/smr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// smr_pkg
// Shared types, constants and helpers for the 3x3 Sobel / mean-removal filter.
// ============================================================================
package smr_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int PIX_W       = 8;
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int ACC_W       = 13;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam int MIN_DIM      = 3;
    localparam int SOBEL_OFFSET = 127;
    localparam int PIX_MAX      = 255;
    localparam int MEAN_GAIN    = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MODE   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_done;
    } t_result;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
    } t_fifo_stat;

    function automatic logic [COL_W-1:0] f_col_last(input logic [WIDTH_BITS-1:0] w);
        logic [COL_W-1:0] res;
        if (w < WIDTH_BITS'(MIN_DIM)) begin
            res = COL_W'(MIN_DIM - 1);
        end else if (w > WIDTH_BITS'(MAX_WIDTH)) begin
            res = COL_W'(MAX_WIDTH - 1);
        end else begin
            res = COL_W'(w - WIDTH_BITS'(1));
        end
        return res;
    endfunction

    function automatic logic [ROW_W-1:0] f_row_last(input logic [HEIGHT_BITS-1:0] h);
        logic [ROW_W-1:0] res;
        if (h < HEIGHT_BITS'(MIN_DIM)) begin
            res = ROW_W'(MIN_DIM - 1);
        end else if (h > HEIGHT_BITS'(MAX_HEIGHT)) begin
            res = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            res = ROW_W'(h - HEIGHT_BITS'(1));
        end
        return res;
    endfunction

endpackage

FILE: src/sobel_mean_removal_3x3_filter.sv
`timescale 1ns / 1ps
// ============================================================================
// sobel_mean_removal_3x3_filter
// 3x3 Sobel (offset 127) or mean-removal filter over an unpadded 8-bit
// frame, two line memories and a six-byte window, clamped 8-bit results.
// ============================================================================
//  channel   | direction | beat carries
//  ----------+-----------+------------------------------------------------
//  s (pixel) | in        | tdata[7:0] pixel_in
//  m (result)| out       | tdata[7:0] pixel_out, tlast frame_done
//  cfg       | in        | index 0 frame_width, 1 frame_height, 2 filter_mode
//
//  One pixel beat per cycle while s tready holds; each pixel passes the line
//  memory read stage, then the kernel and write-back stage, into the queue.
//  The same column recurs no sooner than three beats later, so the
//  read-modify-write of the line memories needs no forwarding.
//  Reset clears position and window; line memories are refilled by the first
//  two rows of each frame, so no clearing pass runs.
//  s tready drops only when the four-slot result queue plus the kernel stage
//  could overflow.
// ============================================================================
module sobel_mean_removal_3x3_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] pixel_in
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [7:0]                      o_m_tdata,   // [7:0] pixel_out
    output logic                            o_m_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [smr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [smr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import smr_pkg::*;

    logic [COL_W-1:0]  r_col_last;
    logic [ROW_W-1:0]  r_row_last;
    logic              r_mode;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    logic [PIX_W-1:0]  r_mem_top [MAX_WIDTH];
    logic [PIX_W-1:0]  r_mem_mid [MAX_WIDTH];
    logic [PIX_W-1:0]  r_q_top;
    logic [PIX_W-1:0]  r_q_mid;

    logic              r_b_valid;
    logic              r_b_emit;
    logic              r_b_last;
    logic [COL_W-1:0]  r_b_col;
    logic [PIX_W-1:0]  r_b_pix;
    logic [PIX_W-1:0]  r_win [6];

    logic              w_accept;
    logic              w_cfg_hit;
    logic              w_push;
    logic [FIFO_CW-1:0] w_load;
    logic signed [ACC_W-1:0] w_sobel;
    logic signed [ACC_W-1:0] w_mean;
    logic signed [ACC_W-1:0] w_acc;
    t_result           w_res;
    t_result           w_out;
    t_fifo_stat        w_stat;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_load      = w_stat.count + FIFO_CW'(r_b_valid);
    assign o_s_tready  = (w_load < FIFO_CW'(FIFO_DEPTH));

    always_comb begin
        w_cfg_hit = 1'b0;
        case (t_cfg_idx'(i_cfg_index))
            CFG_WIDTH:  w_cfg_hit = i_cfg_valid;
            CFG_HEIGHT: w_cfg_hit = i_cfg_valid;
            CFG_MODE:   w_cfg_hit = i_cfg_valid;
            default:    w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= COL_W'(MAX_WIDTH - 1);
            r_row_last <= ROW_W'(MIN_DIM - 1);
            r_mode     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_col_last <= f_col_last(i_cfg_data[WIDTH_BITS-1:0]);
                CFG_HEIGHT: r_row_last <= f_row_last(i_cfg_data[HEIGHT_BITS-1:0]);
                CFG_MODE:   r_mode     <= i_cfg_data[0];
                default:    r_mode     <= r_mode;
            endcase
        end
    end

    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (r_col == r_col_last) begin
            n_col = '0;
            n_row = (r_row == r_row_last) ? '0 : r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= w_accept;
            if (w_cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end else if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // read stage: issue line memory reads, capture beat context
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q_top  <= r_mem_top[r_col];
            r_q_mid  <= r_mem_mid[r_col];
            r_b_col  <= r_col;
            r_b_pix  <= i_s_tdata;
            r_b_emit <= (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
            r_b_last <= (r_col == r_col_last) && (r_row == r_row_last);
        end
        if (r_b_valid) begin
            r_mem_top[r_b_col] <= r_q_mid;
            r_mem_mid[r_b_col] <= r_b_pix;
        end
    end

    // kernel stage: shift window in step with the write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_b_valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_q_top;
            r_win[4] <= r_q_mid;
            r_win[5] <= r_b_pix;
        end
    end

    always_comb begin
        w_sobel = ACC_W'(r_win[0]) + (ACC_W'(r_win[1]) << 1) + ACC_W'(r_win[2])
                - ACC_W'(r_q_top) - (ACC_W'(r_q_mid) << 1) - ACC_W'(r_b_pix)
                + ACC_W'(SOBEL_OFFSET);
        w_mean  = ACC_W'(r_win[4]) * ACC_W'(MEAN_GAIN)
                - ACC_W'(r_win[0]) - ACC_W'(r_win[1]) - ACC_W'(r_win[2])
                - ACC_W'(r_win[3]) - ACC_W'(r_win[5])
                - ACC_W'(r_q_top) - ACC_W'(r_q_mid) - ACC_W'(r_b_pix);
        w_acc   = r_mode ? w_mean : w_sobel;
        if (w_acc < 0) begin
            w_res.pixel = '0;
        end else if (w_acc > ACC_W'(PIX_MAX)) begin
            w_res.pixel = PIX_W'(PIX_MAX);
        end else begin
            w_res.pixel = w_acc[PIX_W-1:0];
        end
        w_res.frame_done = r_b_last;
    end

    assign w_push = r_b_valid && r_b_emit;

    smr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_out),
        .o_stat  (w_stat)
    );

    assign o_m_tdata = w_out.pixel;
    assign o_m_tlast = w_out.frame_done;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_stat.count != FIFO_CW'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_stage_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> $past(w_accept))
        else $error("kernel stage valid without accepted beat");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_cfg_hit && r_col == r_col_last) |=> (r_col == '0))
        else $error("column did not wrap at row end");
`endif

endmodule

FILE: src/smr_out_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// smr_out_fifo
// Four-slot result queue that decouples the filter core from the output beat.
// ============================================================================
module smr_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  smr_pkg::t_result     i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output smr_pkg::t_result     o_data,
    output smr_pkg::t_fifo_stat  o_stat
);
    import smr_pkg::*;

    t_result             r_slot [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [FIFO_CW-1:0]  r_count;
    logic [FIFO_CW-1:0]  n_count;
    logic                w_pop;

    assign o_valid      = (r_count != '0);
    assign o_data       = r_slot[r_rd_ptr];
    assign o_stat.count = r_count;
    assign w_pop        = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + FIFO_CW'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule
